### hdl/ffha_pkg.sv
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int UNIT_W     = 12;
    localparam int LINK_W     = 13;
    localparam int HEAP_UNITS = 4096;

    // Link value that marks the end of the free list.
    localparam logic [LINK_W-1:0] END_MARK = LINK_W'(HEAP_UNITS);
    localparam logic [UNIT_W-1:0] FULL_UNITS = UNIT_W'(HEAP_UNITS - 1);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic              used;
        logic [UNIT_W-1:0] units;
        logic [LINK_W-1:0] nxt;
        logic [LINK_W-1:0] prv;
    } entry_t;

    typedef struct packed {
        logic used;
        logic units;
        logic nxt;
        logic prv;
    } fmask_t;

    typedef struct packed {
        logic              en;
        logic [UNIT_W-1:0] addr;
        fmask_t            mask;
        entry_t            data;
    } wr_t;

    typedef struct packed {
        logic              en;
        logic [UNIT_W-1:0] addr;
    } rd_t;

    typedef struct packed {
        logic              valid;
        logic              ok;
        logic [15:0]       offset;
        logic [UNIT_W-1:0] units_used;
        logic              heap_empty;
        logic [UNIT_W-1:0] largest;
    } res_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_A_CHK,
        ST_A_WC,
        ST_A_WR,
        ST_A_WP,
        ST_A_WN,
        ST_F_CHK,
        ST_F_WSTEP,
        ST_F_NXT,
        ST_F_RDN,
        ST_F_WH,
        ST_F_WP,
        ST_F_WR,
        ST_L_START,
        ST_L_STEP
    } state_t;

endpackage

### hdl/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: memory, sequencer and result register.
`timescale 1ns / 1ps
// The heap is 4096 units of 16 bytes; every block has a one-unit header.
// A request is an item taken at a rising edge with start high and busy low:
// kind 0 allocates size_bytes (rounded up to units) from the first free block
// large enough, kind 1 frees the block whose payload starts at handle and
// merges it with free neighbours on both sides.
// Each item gives one result, shown for exactly one cycle with done high:
// ok, payload_offset, units_used, heap_empty and largest_free_bytes.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// Latency depends on the free list, since all state lives in one header memory
// with one read and one write a cycle. An allocate walks the free blocks up to
// the fit, writes the taken header, the remainder header on a split and the
// links of its free neighbours, then walks the whole free list to recompute the
// largest block; the result then passes through the result register.
// A free checks the header, walks the free blocks below it, reads the next block
// if it merges with it, writes the header and the neighbours' links, then makes the same pass.
// A refused free returns after the alignment or header check, a failed allocate
// once the free list is empty or walked to its end. One item is in flight at a time.
// After reset the init state writes the header of the single free block, with
// busy high; no other entry is cleared.
module first_fit_heap_allocator
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        kind,
    input  logic [15:0] size_bytes,
    input  logic [15:0] handle,
    output logic        done,
    output logic        ok,
    output logic [15:0] payload_offset,
    output logic [11:0] units_used,
    output logic        heap_empty,
    output logic [15:0] largest_free_bytes
);

    rd_t    rd;
    wr_t    wr;
    entry_t rdata;
    res_t   res;

    logic              done_reg;
    logic              ok_reg;
    logic [15:0]       offset_reg;
    logic [UNIT_W-1:0] units_used_reg;
    logic              heap_empty_reg;
    logic [UNIT_W-1:0] largest_reg;

    ffha_mem u_mem (
        .clk   (clk),
        .wr    (wr),
        .rd    (rd),
        .rdata (rdata)
    );

    ffha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .kind       (kind),
        .size_bytes (size_bytes),
        .handle     (handle),
        .rdata      (rdata),
        .busy       (busy),
        .rd         (rd),
        .wr         (wr),
        .res        (res)
    );

    // The result register holds each result for the one cycle it is offered.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            ok_reg         <= res.ok;
            offset_reg     <= res.offset;
            units_used_reg <= res.units_used;
            heap_empty_reg <= res.heap_empty;
            largest_reg    <= res.largest;
        end
    end

    assign done               = done_reg;
    assign ok                 = ok_reg;
    assign payload_offset     = offset_reg;
    assign units_used         = units_used_reg;
    assign heap_empty         = heap_empty_reg;
    assign largest_free_bytes = {largest_reg, 4'b0000};

    // A result always comes back with the sequencer already idle.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while the sequencer is still busy");

    // An accepted item either keeps the block busy or returns at once.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither started nor returned");

    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !ok) |-> (payload_offset == 16'd0))
        else $error("failed request returned a non-zero offset");

    a_empty_units: assert property (@(posedge clk) disable iff (!rst_n)
        (done && heap_empty) |-> (units_used == 12'd0))
        else $error("empty heap reports units in use");

endmodule

### hdl/ffha_mem.sv
// Header memory: one entry per heap unit, per-field write enables, registered read.
`timescale 1ns / 1ps
module ffha_mem
    import ffha_pkg::*;
(
    input  logic   clk,
    input  wr_t    wr,
    input  rd_t    rd,
    output entry_t rdata
);

    entry_t mem [HEAP_UNITS];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            if (wr.mask.used)  mem[wr.addr].used  <= wr.data.used;
            if (wr.mask.units) mem[wr.addr].units <= wr.data.units;
            if (wr.mask.nxt)   mem[wr.addr].nxt   <= wr.data.nxt;
            if (wr.mask.prv)   mem[wr.addr].prv   <= wr.data.prv;
        end
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/ffha_ctrl.sv
// Sequencer that walks the free list and rewrites block headers in the memory.
`timescale 1ns / 1ps
module ffha_ctrl
    import ffha_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        kind,
    input  logic [15:0] size_bytes,
    input  logic [15:0] handle,
    input  entry_t      rdata,
    output logic        busy,
    output rd_t         rd,
    output wr_t         wr,
    output res_t        res
);

    state_t state_reg, state_next;

    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] p_reg, p_next;
    logic [LINK_W-1:0] n_reg, n_next;
    logic [LINK_W-1:0] r_reg, r_next;
    logic [LINK_W-1:0] want_reg, want_next;
    logic [UNIT_W-1:0] hdr_reg, hdr_next;
    logic [UNIT_W-1:0] uh_reg, uh_next;
    logic [UNIT_W-1:0] pu_reg, pu_next;
    logic [UNIT_W-1:0] best_reg, best_next;
    logic [UNIT_W-1:0] largest_reg, largest_next;
    logic [UNIT_W-1:0] used_units_reg, used_units_next;
    logic [LINK_W-1:0] used_blocks_reg, used_blocks_next;
    logic [LINK_W-1:0] first_reg, first_next;
    logic [LINK_W-1:0] last_reg, last_next;
    logic              exact_reg, exact_next;
    logic              split_reg, split_next;
    logic              mp_reg, mp_next;
    logic              ok_reg, ok_next;
    logic [15:0]       off_reg, off_next;

    logic [16:0]       want_sum;
    logic [LINK_W-1:0] want_calc;
    logic [UNIT_W-1:0] hdr_calc;
    logic              fits;
    logic [LINK_W:0]   r_sum;
    logic              r_in_heap;
    logic              walk_more;
    logic              free_walk_more;
    logic              merge_next;
    logic              merge_prev;
    logic [UNIT_W-1:0] best_cand;
    logic [LINK_W-1:0] link_a;
    logic [LINK_W-1:0] link_b;
    logic [LINK_W-1:0] merged_hdr;

    assign want_sum  = {1'b0, size_bytes} + 17'd15;
    assign want_calc = want_sum[16:4];
    assign hdr_calc  = handle[15:4] - 12'd1;
    assign fits      = {1'b0, rdata.units} >= want_reg;
    assign r_sum     = {1'b0, cur_reg} + {1'b0, want_reg} + 14'd1;
    assign r_in_heap = r_sum < {1'b0, END_MARK};
    assign walk_more = rdata.nxt < END_MARK;
    assign free_walk_more = (rdata.nxt < END_MARK) && (rdata.nxt <= {1'b0, hdr_reg});
    assign merge_next = (cur_reg < END_MARK) &&
                        (({2'b00, hdr_reg} + {2'b00, uh_reg} + 14'd1) == {1'b0, cur_reg});
    assign merge_prev = (p_reg < END_MARK) &&
                        (({1'b0, p_reg} + {2'b00, pu_reg} + 14'd1) == {2'b00, hdr_reg});
    assign best_cand  = (rdata.units > best_reg) ? rdata.units : best_reg;
    assign link_a     = exact_reg ? n_reg : r_reg;
    assign link_b     = exact_reg ? p_reg : r_reg;
    assign merged_hdr = mp_reg ? p_reg : {1'b0, hdr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            largest_reg     <= FULL_UNITS;
            used_units_reg  <= '0;
            used_blocks_reg <= '0;
            first_reg       <= '0;
            last_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            largest_reg     <= largest_next;
            used_units_reg  <= used_units_next;
            used_blocks_reg <= used_blocks_next;
            first_reg       <= first_next;
            last_reg        <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg   <= cur_next;
        p_reg     <= p_next;
        n_reg     <= n_next;
        r_reg     <= r_next;
        want_reg  <= want_next;
        hdr_reg   <= hdr_next;
        uh_reg    <= uh_next;
        pu_reg    <= pu_next;
        best_reg  <= best_next;
        exact_reg <= exact_next;
        split_reg <= split_next;
        mp_reg    <= mp_next;
        ok_reg    <= ok_next;
        off_reg   <= off_next;
    end

    // Next state and working registers.
    always_comb
    begin
        state_next       = state_reg;
        cur_next         = cur_reg;
        p_next           = p_reg;
        n_next           = n_reg;
        r_next           = r_reg;
        want_next        = want_reg;
        hdr_next         = hdr_reg;
        uh_next          = uh_reg;
        pu_next          = pu_reg;
        best_next        = best_reg;
        largest_next     = largest_reg;
        used_units_next  = used_units_reg;
        used_blocks_next = used_blocks_reg;
        first_next       = first_reg;
        last_next        = last_reg;
        exact_next       = exact_reg;
        split_next       = split_reg;
        mp_next          = mp_reg;
        ok_next          = ok_reg;
        off_next         = off_reg;
        case (state_reg)
            ST_INIT:
            begin
                state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    want_next = want_calc;
                    hdr_next  = hdr_calc;
                    cur_next  = first_reg;
                    if (kind == KIND_ALLOC)
                    begin
                        if (first_reg < END_MARK) state_next = ST_A_CHK;
                    end
                    else if (handle[3:0] == 4'd0)
                    begin
                        state_next = ST_F_CHK;
                    end
                end
            end
            ST_A_CHK:
            begin
                if (fits)
                begin
                    p_next           = rdata.prv;
                    n_next           = rdata.nxt;
                    uh_next          = rdata.units;
                    r_next           = r_sum[LINK_W-1:0];
                    exact_next       = rdata.units == want_reg[UNIT_W-1:0];
                    split_next       = (rdata.units != want_reg[UNIT_W-1:0]) && r_in_heap;
                    used_units_next  = used_units_reg + want_reg[UNIT_W-1:0];
                    used_blocks_next = used_blocks_reg + 13'd1;
                    ok_next          = 1'b1;
                    off_next         = {cur_reg[UNIT_W-1:0] + 12'd1, 4'b0000};
                    state_next       = ST_A_WC;
                end
                else if (walk_more)
                begin
                    cur_next = rdata.nxt;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_A_WC:
            begin
                if (split_reg)      state_next = ST_A_WR;
                else if (exact_reg) state_next = ST_A_WP;
                else                state_next = ST_L_START;
            end
            ST_A_WR:
            begin
                state_next = ST_A_WP;
            end
            ST_A_WP:
            begin
                if (!(p_reg < END_MARK)) first_next = link_a;
                state_next = ST_A_WN;
            end
            ST_A_WN:
            begin
                if (!(n_reg < END_MARK)) last_next = link_b;
                state_next = ST_L_START;
            end
            ST_F_CHK:
            begin
                if (rdata.used)
                begin
                    uh_next          = rdata.units;
                    used_units_next  = used_units_reg - rdata.units;
                    used_blocks_next = used_blocks_reg - 13'd1;
                    ok_next          = 1'b1;
                    off_next         = '0;
                    p_next           = END_MARK;
                    cur_next         = first_reg;
                    if ((first_reg < END_MARK) && (first_reg <= {1'b0, hdr_reg}))
                        state_next = ST_F_WSTEP;
                    else
                        state_next = ST_F_NXT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_F_WSTEP:
            begin
                p_next   = cur_reg;
                pu_next  = rdata.units;
                cur_next = rdata.nxt;
                if (!free_walk_more) state_next = ST_F_NXT;
            end
            ST_F_NXT:
            begin
                mp_next = merge_prev;
                n_next  = cur_reg;
                if (merge_next) state_next = ST_F_RDN;
                else            state_next = ST_F_WH;
            end
            ST_F_RDN:
            begin
                uh_next    = uh_reg + rdata.units + 12'd1;
                n_next     = rdata.nxt;
                state_next = ST_F_WH;
            end
            ST_F_WH:
            begin
                state_next = ST_F_WP;
            end
            ST_F_WP:
            begin
                if (!mp_reg && !(p_reg < END_MARK)) first_next = {1'b0, hdr_reg};
                state_next = ST_F_WR;
            end
            ST_F_WR:
            begin
                if (!(n_reg < END_MARK)) last_next = merged_hdr;
                state_next = ST_L_START;
            end
            ST_L_START:
            begin
                best_next = '0;
                if (first_reg < END_MARK)
                begin
                    state_next = ST_L_STEP;
                end
                else
                begin
                    largest_next = '0;
                    state_next   = ST_IDLE;
                end
            end
            ST_L_STEP:
            begin
                best_next = best_cand;
                if (!walk_more)
                begin
                    largest_next = best_cand;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory accesses, busy and the result of each item.
    always_comb
    begin
        busy              = state_reg != ST_IDLE;
        rd                = '0;
        wr                = '0;
        res               = '0;
        res.ok            = ok_reg;
        res.offset        = off_reg;
        res.units_used    = used_units_reg;
        res.heap_empty    = used_blocks_reg == '0;
        res.largest       = largest_reg;
        case (state_reg)
            ST_INIT:
            begin
                wr.en   = 1'b1;
                wr.addr = '0;
                wr.mask = '1;
                wr.data = '{used: 1'b0, units: FULL_UNITS, nxt: END_MARK, prv: END_MARK};
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (kind == KIND_ALLOC)
                    begin
                        rd.en   = first_reg < END_MARK;
                        rd.addr = first_reg[UNIT_W-1:0];
                        if (!(first_reg < END_MARK))
                        begin
                            res.valid  = 1'b1;
                            res.ok     = 1'b0;
                            res.offset = '0;
                        end
                    end
                    else
                    begin
                        rd.en   = handle[3:0] == 4'd0;
                        rd.addr = hdr_calc;
                        if (handle[3:0] != 4'd0)
                        begin
                            res.valid  = 1'b1;
                            res.ok     = 1'b0;
                            res.offset = '0;
                        end
                    end
                end
            end
            ST_A_CHK:
            begin
                if (!fits)
                begin
                    rd.en   = walk_more;
                    rd.addr = rdata.nxt[UNIT_W-1:0];
                    if (!walk_more)
                    begin
                        res.valid  = 1'b1;
                        res.ok     = 1'b0;
                        res.offset = '0;
                    end
                end
            end
            ST_A_WC:
            begin
                wr.en         = 1'b1;
                wr.addr       = cur_reg[UNIT_W-1:0];
                wr.mask.used  = 1'b1;
                wr.mask.units = 1'b1;
                wr.mask.nxt   = exact_reg || split_reg;
                wr.mask.prv   = exact_reg || split_reg;
                wr.data       = '{used: 1'b1, units: want_reg[UNIT_W-1:0],
                                  nxt: END_MARK, prv: END_MARK};
            end
            ST_A_WR:
            begin
                wr.en   = 1'b1;
                wr.addr = r_reg[UNIT_W-1:0];
                wr.mask = '1;
                wr.data = '{used: 1'b0, units: uh_reg - want_reg[UNIT_W-1:0] - 12'd1,
                            nxt: n_reg, prv: p_reg};
            end
            ST_A_WP:
            begin
                wr.en          = p_reg < END_MARK;
                wr.addr        = p_reg[UNIT_W-1:0];
                wr.mask.nxt    = 1'b1;
                wr.data.nxt    = link_a;
            end
            ST_A_WN:
            begin
                wr.en          = n_reg < END_MARK;
                wr.addr        = n_reg[UNIT_W-1:0];
                wr.mask.prv    = 1'b1;
                wr.data.prv    = link_b;
            end
            ST_F_CHK:
            begin
                if (!rdata.used)
                begin
                    res.valid  = 1'b1;
                    res.ok     = 1'b0;
                    res.offset = '0;
                end
                else
                begin
                    rd.en   = (first_reg < END_MARK) && (first_reg <= {1'b0, hdr_reg});
                    rd.addr = first_reg[UNIT_W-1:0];
                end
            end
            ST_F_WSTEP:
            begin
                rd.en   = free_walk_more;
                rd.addr = rdata.nxt[UNIT_W-1:0];
            end
            ST_F_NXT:
            begin
                rd.en   = merge_next;
                rd.addr = cur_reg[UNIT_W-1:0];
            end
            ST_F_WH:
            begin
                wr.en   = 1'b1;
                wr.addr = hdr_reg;
                wr.mask = '1;
                wr.data = '{used: 1'b0, units: uh_reg, nxt: n_reg, prv: p_reg};
            end
            ST_F_WP:
            begin
                wr.en   = p_reg < END_MARK;
                wr.addr = p_reg[UNIT_W-1:0];
                if (mp_reg)
                begin
                    wr.mask.units = 1'b1;
                    wr.mask.nxt   = 1'b1;
                    wr.data.units = pu_reg + uh_reg + 12'd1;
                    wr.data.nxt   = n_reg;
                end
                else
                begin
                    wr.mask.nxt = 1'b1;
                    wr.data.nxt = {1'b0, hdr_reg};
                end
            end
            ST_F_WR:
            begin
                wr.en       = n_reg < END_MARK;
                wr.addr     = n_reg[UNIT_W-1:0];
                wr.mask.prv = 1'b1;
                wr.data.prv = merged_hdr;
            end
            ST_L_START:
            begin
                rd.en   = first_reg < END_MARK;
                rd.addr = first_reg[UNIT_W-1:0];
                if (!(first_reg < END_MARK))
                begin
                    res.valid   = 1'b1;
                    res.largest = '0;
                end
            end
            ST_L_STEP:
            begin
                rd.en   = walk_more;
                rd.addr = rdata.nxt[UNIT_W-1:0];
                if (!walk_more)
                begin
                    res.valid   = 1'b1;
                    res.largest = best_cand;
                end
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule
